FILE: rtl/core/hhlp_pkg.sv
// types, constants and helpers shared by the http header line parser
`default_nettype none

package hhlp_pkg;

    localparam int unsigned W_BYTE = 8;
    localparam int unsigned W_OFF  = 14;
    localparam int unsigned W_LEN  = 13;
    localparam int unsigned W_CFG  = 32;

    localparam logic [W_OFF-1:0] HEADER_LIMIT_RESET = 14'd8192;
    localparam logic [2:0]       ADDR_HEADER_LIMIT  = 3'd0;

    localparam logic [W_BYTE-1:0] CH_COLON = 8'h3A;
    localparam logic [W_BYTE-1:0] CH_DASH  = 8'h2D;
    localparam logic [W_BYTE-1:0] CH_UNDER = 8'h5F;
    localparam logic [W_BYTE-1:0] CH_CR    = 8'h0D;
    localparam logic [W_BYTE-1:0] CH_LF    = 8'h0A;
    localparam logic [W_BYTE-1:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        ST_RECEIVING = 2'd0,
        ST_READY     = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    typedef struct packed {
        logic [W_BYTE-1:0] data_byte;
        logic              first_byte;
    } t_item;

    typedef struct packed {
        logic [W_BYTE-1:0] out_byte;
        t_status           status;
        logic              line_done;
        logic [W_LEN-1:0]  key_pos;
        logic [W_LEN-1:0]  key_len;
        logic [W_OFF-1:0]  value_pos;
        logic [W_LEN-1:0]  value_len;
        logic [W_OFF-1:0]  headers_end;
    } t_result;

    function automatic logic is_lower(input logic [W_BYTE-1:0] b);
        return (b >= 8'h61) && (b <= 8'h7A);
    endfunction

    function automatic logic name_char_ok(input logic [W_BYTE-1:0] b);
        logic upper;
        logic digit;
        upper = (b >= 8'h41) && (b <= 8'h5A);
        digit = (b >= 8'h30) && (b <= 8'h39);
        return is_lower(b) || upper || digit || (b == CH_DASH) || (b == CH_UNDER);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hhlp_cfg.sv
// apb register block holding the header byte limit
`default_nettype none

module hhlp_cfg
    import hhlp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [W_CFG-1:0] pwdata,
    output logic      [W_CFG-1:0] prdata,
    output logic                  pready,
    output logic      [W_OFF-1:0] o_header_limit
);

    logic [W_OFF-1:0] r_header_limit;
    logic [W_OFF-1:0] n_header_limit;
    logic             sel_limit;

    assign sel_limit = (paddr[2] == ADDR_HEADER_LIMIT[2]);

    always_comb begin
        n_header_limit = r_header_limit;
        if (psel && penable && pwrite && sel_limit) begin
            n_header_limit = pwdata[W_OFF-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_limit <= HEADER_LIMIT_RESET;
        end else begin
            r_header_limit <= n_header_limit;
        end
    end

    assign prdata         = sel_limit ? {{(W_CFG-W_OFF){1'b0}}, r_header_limit} : '0;
    assign pready         = 1'b1;
    assign o_header_limit = r_header_limit;

endmodule

`default_nettype wire

FILE: rtl/core/hhlp_parse.sv
// per-byte parse state and combinational line classification
`default_nettype none

module hhlp_parse
    import hhlp_pkg::*;
#(
    parameter int unsigned MAX_HEADER_BYTES = 8192
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire t_item            i_item,
    input  wire logic [W_OFF-1:0] i_header_limit,
    output t_result               o_result
);

    localparam int unsigned    W_LIM = 17;
    localparam logic [W_LIM-1:0] MAX_LIM = W_LIM'(MAX_HEADER_BYTES);

    t_status          r_status,    n_status,    s_status;
    logic [W_OFF-1:0] r_count,     n_count,     s_count;
    logic [W_OFF-1:0] r_line,      n_line,      s_line;
    logic [W_OFF-1:0] r_colon_off, n_colon_off, s_colon_off;
    logic             r_colon,     n_colon,     s_colon;
    logic             r_clean,     n_clean,     s_clean;
    logic             r_cr,        n_cr,        s_cr;
    logic [W_OFF-1:0] r_end,       n_end,       s_end;

    logic [W_LIM-1:0] lim;
    logic [W_OFF-1:0] cr_at;
    logic [W_OFF-1:0] vpos;
    logic [W_OFF-1:0] klen_w;
    logic [W_OFF-1:0] vlen_w;
    logic [W_BYTE-1:0] b;

    assign b = i_item.data_byte;
    assign lim = ({3'b000, i_header_limit} > MAX_LIM) ? MAX_LIM : {3'b000, i_header_limit};

    // first byte of a request restarts from a clean state
    always_comb begin
        if (i_item.first_byte) begin
            s_status    = ST_RECEIVING;
            s_count     = '0;
            s_line      = '0;
            s_colon_off = '0;
            s_colon     = 1'b0;
            s_clean     = 1'b1;
            s_cr        = 1'b0;
            s_end       = '0;
        end else begin
            s_status    = r_status;
            s_count     = r_count;
            s_line      = r_line;
            s_colon_off = r_colon_off;
            s_colon     = r_colon;
            s_clean     = r_clean;
            s_cr        = r_cr;
            s_end       = r_end;
        end
    end

    assign cr_at  = s_count - 14'd1;
    assign vpos   = s_colon_off + 14'd1;
    assign klen_w = s_colon_off - s_line;
    assign vlen_w = cr_at - vpos;

    always_comb begin
        n_status    = s_status;
        n_count     = s_count;
        n_line      = s_line;
        n_colon_off = s_colon_off;
        n_colon     = s_colon;
        n_clean     = s_clean;
        n_cr        = s_cr;
        n_end       = s_end;

        o_result           = '0;
        o_result.out_byte  = b;

        if (s_status == ST_RECEIVING) begin
            if (!s_colon && is_lower(b)) begin
                o_result.out_byte = b - CASE_GAP;
            end
            if (s_cr && (b == CH_LF)) begin
                if (cr_at == s_line) begin
                    n_status = ST_READY;
                    n_end    = s_count + 14'd1;
                end else if (!s_colon || (s_colon_off == s_line) || !s_clean) begin
                    n_status = ST_MALFORMED;
                end else begin
                    o_result.line_done = 1'b1;
                    o_result.key_pos   = s_line[W_LEN-1:0];
                    o_result.key_len   = klen_w[W_LEN-1:0];
                    o_result.value_pos = vpos;
                    o_result.value_len = vlen_w[W_LEN-1:0];
                end
                n_line  = s_count + 14'd1;
                n_colon = 1'b0;
                n_clean = 1'b1;
                n_cr    = 1'b0;
            end else begin
                if (s_cr && !s_colon) begin
                    n_clean = 1'b0;
                end
                if (b == CH_CR) begin
                    n_cr = 1'b1;
                end else begin
                    n_cr = 1'b0;
                    if (!s_colon) begin
                        if (b == CH_COLON) begin
                            n_colon     = 1'b1;
                            n_colon_off = s_count;
                        end else if (!name_char_ok(b)) begin
                            n_clean = 1'b0;
                        end
                    end
                end
            end
            n_count = s_count + 14'd1;
            if ((n_status == ST_RECEIVING) && ({3'b000, n_count} >= lim)) begin
                n_status = ST_TOO_LARGE;
            end
        end

        o_result.status      = n_status;
        o_result.headers_end = (n_status == ST_READY) ? n_end : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= ST_RECEIVING;
            r_count     <= '0;
            r_line      <= '0;
            r_colon_off <= '0;
            r_colon     <= 1'b0;
            r_clean     <= 1'b1;
            r_cr        <= 1'b0;
            r_end       <= '0;
        end else if (i_step) begin
            r_status    <= n_status;
            r_count     <= n_count;
            r_line      <= n_line;
            r_colon_off <= n_colon_off;
            r_colon     <= n_colon;
            r_clean     <= n_clean;
            r_cr        <= n_cr;
            r_end       <= n_end;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/http_header_line_parser_top.sv
// http header line parser: a request byte in, a classified byte with line info out
//
// input stream: one request byte per transaction in s_axis_tdata, s_axis_tuser
// set on the first byte of a new request (clears all parse state)
// output stream: one result transaction per input byte, carrying the byte
// (uppercased inside header names), the request status, a line_done flag and
// the key/value offsets and lengths of a completed header line, plus the
// header end offset once the blank line is seen
// throughput: one byte per cycle when the receiver does not stall; the parse state
// is a single register set updated by one pass of logic between the input and the
// result register; a taken byte passes the input register, then the result register
// apb port: header_limit at addresses 0 to 3, written on the access cycle
// reset: status receiving, all offsets zero, header_limit 8192, both
// pipeline registers empty
// when the receiver stalls, the result register holds and the input register
// keeps one more byte; s_axis_tready drops only when both are full
`default_nettype none

module http_header_line_parser_top
    import hhlp_pkg::*;
#(
    parameter int unsigned MAX_HEADER_BYTES = 8192
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,  // data_byte
    input  wire logic [0:0]       s_axis_tuser,  // first_byte
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // out_byte, key_pos, key_len, value_pos, value_len, headers_end, zero pad
    output logic      [79:0]      m_axis_tdata,
    output logic      [2:0]       m_axis_tuser,  // status, line_done
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [W_CFG-1:0] pwdata,
    output logic      [W_CFG-1:0] prdata,
    output logic                  pready
);

    logic             r_in_valid;
    t_item            r_in;
    logic             r_out_valid;
    t_result          r_out;
    t_result          result;
    logic             advance;
    logic             step;
    logic [W_OFF-1:0] header_limit;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    hhlp_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_header_limit (header_limit)
    );

    hhlp_parse #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_in),
        .i_header_limit (header_limit),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.data_byte  <= s_axis_tdata;
            r_in.first_byte <= s_axis_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out.headers_end, r_out.value_len, r_out.value_pos,
                            r_out.key_len, r_out.key_pos, r_out.out_byte};
    assign m_axis_tuser  = {r_out.line_done, r_out.status};

    // a completed header line comes with receiving or, at the limit, too large
    a_line_done_receiving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |->
            ((m_axis_tuser[1:0] == ST_RECEIVING) || (m_axis_tuser[1:0] == ST_TOO_LARGE)))
        else $error("line_done with ready or malformed status");

    // header end offset is only shown with ready status
    a_end_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] != ST_READY)) |-> (m_axis_tdata[74:61] == '0))
        else $error("headers_end nonzero without ready status");

    // a byte leaving the input register always lands in the result register
    a_step_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("stepped byte lost");

endmodule

`default_nettype wire
